// ===== rtl/core/sffvc_pkg.sv =====
// Shared types, constants and helpers for the speed feedforward voltage compensation block.
// Used by the divider, datapath, controller, top level and testbench; depends on nothing.
`default_nettype none
package sffvc_pkg;

  localparam int TABLE_POINTS_DFLT = 9;

  // shared divider: wide dividend for the gain, 32-bit window for interpolation
  localparam int DIV_NW = 45;
  localparam int DIV_DW = 32;
  localparam int DIV_SHORT_BITS = 32;

  // configuration register indexes
  localparam logic [2:0] REG_SPIKE_LIMIT  = 3'd0;
  localparam logic [2:0] REG_FAST_ALPHA   = 3'd1;
  localparam logic [2:0] REG_SLOW_ALPHA   = 3'd2;
  localparam logic [2:0] REG_REFERENCE    = 3'd3;
  localparam logic [2:0] REG_VOLT_FLOOR   = 3'd4;
  localparam logic [2:0] REG_VOLT_CEILING = 3'd5;
  localparam logic [2:0] REG_GAIN_FLOOR   = 3'd6;
  localparam logic [2:0] REG_GAIN_CEILING = 3'd7;

  localparam logic [14:0] RST_SPIKE_LIMIT  = 15'd500;
  localparam logic [15:0] RST_FAST_ALPHA   = 16'd16384;
  localparam logic [15:0] RST_SLOW_ALPHA   = 16'd655;
  localparam logic [14:0] RST_REFERENCE    = 15'd12000;
  localparam logic [14:0] RST_VOLT_FLOOR   = 15'd6000;
  localparam logic [14:0] RST_VOLT_CEILING = 15'd16800;
  localparam logic [15:0] RST_GAIN_FLOOR   = 16'd13107;
  localparam logic [15:0] RST_GAIN_CEILING = 16'd26214;
  localparam logic [31:0] RST_VOLTAGE_Q16  = 32'(12000 * 65536);

  localparam logic OP_WRITE_POINT = 1'b0;
  localparam logic OP_TICK        = 1'b1;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LIMIT,
    DP_FAST_MUL,
    DP_FAST_UPD,
    DP_SLOW_MUL,
    DP_SLOW_UPD,
    DP_SRCH_INIT,
    DP_SRCH_STEP,
    DP_INTERP_MUL0,
    DP_INTERP_MUL1,
    DP_INTERP_SUM,
    DP_INTERP_DIV,
    DP_INTERP_DONE,
    DP_GAIN_DIV,
    DP_GAIN_DONE,
    DP_COMP_MUL,
    DP_COMP_DONE,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
    logic   side;
  } cmd_t;

  typedef struct packed {
    logic srch_done;
    logic srch_interp;
    logic div_done;
  } sts_t;

  function automatic logic [14:0] dflt_speed(input int idx);
    logic [14:0] s;
    case (idx)
      0: s = 15'd0;
      1: s = 15'd10;
      2: s = 15'd20;
      3: s = 15'd30;
      4: s = 15'd50;
      5: s = 15'd80;
      6: s = 15'd120;
      7: s = 15'd160;
      8: s = 15'd200;
      default: s = 15'(200 + 40 * (idx - 8));
    endcase
    return s;
  endfunction

  function automatic logic signed [16:0] apply_sign(input logic neg,
                                                    input logic signed [16:0] v);
    return neg ? -v : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sffvc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on sffvc_pkg for its widths.
`default_nettype none
module sffvc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         short_mode,
  input  wire logic [sffvc_pkg::DIV_NW-1:0] dividend,
  input  wire logic [sffvc_pkg::DIV_DW-1:0] divisor,
  output logic      [sffvc_pkg::DIV_NW-1:0] quotient,
  output logic                              done
);

  localparam int NW = sffvc_pkg::DIV_NW;
  localparam int DW = sffvc_pkg::DIV_DW;

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      // short window: left-align a 32-bit dividend
      quo_r  <= short_mode ? (dividend << (NW - sffvc_pkg::DIV_SHORT_BITS)) : dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
      cnt_r  <= short_mode ? 6'(sffvc_pkg::DIV_SHORT_BITS) : 6'(NW);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/sffvc_dp.sv =====
// Datapath: configuration, point tables, averages, segment search, multiplier, output registers.
// Depends on sffvc_pkg and sffvc_div; driven by sffvc_ctrl commands.
`default_nettype none
module sffvc_dp #(
  parameter int TABLE_POINTS = sffvc_pkg::TABLE_POINTS_DFLT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sffvc_pkg::cmd_t      cmd,
  output sffvc_pkg::sts_t           sts,
  input  wire logic                 in_op,
  input  wire logic [14:0]          in_voltage_mv,
  input  wire logic signed [15:0]   in_left_target,
  input  wire logic signed [15:0]   in_right_target,
  input  wire logic                 in_table_side,
  input  wire logic [3:0]           in_point_index,
  input  wire logic [14:0]          in_point_speed,
  input  wire logic signed [14:0]   in_point_pwm,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata,
  output logic signed [14:0]        out_left_ff_pwm,
  output logic signed [14:0]        out_right_ff_pwm,
  output logic [14:0]               out_slow_avg_mv,
  output logic [14:0]               out_fast_avg_mv
);

  localparam int IW = $clog2(TABLE_POINTS);

  // configuration
  logic [14:0] spike_r, ref_r, vfl_r, vce_r;
  logic [15:0] fa_r, sa_r, gfl_r, gce_r;

  // point tables
  logic [14:0]        spd_r [2][TABLE_POINTS];
  logic signed [14:0] pwm_r [2][TABLE_POINTS];

  // tick operands and working registers
  logic [14:0]        vin_r;
  logic signed [15:0] tl_r, tr_r;
  logic [31:0]        raw_r, fast_r, slow_r;
  logic signed [51:0] prod_r;
  logic [16:0]        mag_r;
  logic               tneg_r;
  logic [IW-1:0]      idx_r;
  logic [14:0]        s0_r, s1_r;
  logic signed [14:0] p0_r, p1_r;
  logic               srch_done_r, srch_interp_r;
  logic signed [31:0] num_r;
  logic               nneg_r;
  logic               vz_r;
  logic [15:0]        gain_r;
  logic signed [16:0] duty_r [2];
  logic signed [14:0] res_r [2];
  logic signed [14:0] outl_r, outr_r;
  logic [14:0]        outs_r, outf_r;

  // divider
  logic                         div_start, div_short, div_done;
  logic [sffvc_pkg::DIV_NW-1:0] div_nd, div_q;
  logic [sffvc_pkg::DIV_DW-1:0] div_dv;

  // combinational helpers
  logic signed [15:0] tgt_c;
  logic signed [16:0] t17_c;
  logic [16:0]        mag_c;
  logic [16:0]        s_first_c, s_last_c;
  logic [14:0]        s_rd_c;
  logic signed [14:0] p_rd_c;
  logic [31:0]        raw_in_c;
  logic [30:0]        lim_c;
  logic [32:0]        hi_c;
  logic signed [33:0] lo_c;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] rnd16_c, rnd14_c;
  logic signed [33:0] upd_c;
  logic [31:0]        vlo_c, vhi_c, v1_c, v2_c;
  logic [44:0]        g1_c;
  logic signed [51:0] comp_c;
  logic signed [16:0] q_c;
  logic [14:0]        ds_c;
  logic signed [16:0] dp_c;

  assign tgt_c     = cmd.side ? tr_r : tl_r;
  assign t17_c     = 17'(tgt_c);
  assign mag_c     = tgt_c[15] ? 17'(-t17_c) : 17'(t17_c);
  assign s_first_c = 17'(spd_r[cmd.side][0]);
  assign s_last_c  = 17'(spd_r[cmd.side][TABLE_POINTS-1]);
  assign s_rd_c    = spd_r[cmd.side][idx_r];
  assign p_rd_c    = pwm_r[cmd.side][idx_r];

  assign raw_in_c = {1'b0, vin_r, 16'b0};
  assign lim_c    = {spike_r, 16'b0};
  assign hi_c     = {1'b0, slow_r} + 33'(lim_c);
  assign lo_c     = $signed({2'b0, slow_r}) - $signed(34'(lim_c));

  assign ds_c = s1_r - s0_r;
  assign dp_c = 17'(p1_r) - 17'(p0_r);

  // one shared multiplier, operands chosen by the command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      sffvc_pkg::DP_FAST_MUL: begin
        mul_a = $signed({2'b0, raw_r}) - $signed({2'b0, fast_r});
        mul_b = $signed({2'b0, fa_r});
      end
      sffvc_pkg::DP_SLOW_MUL: begin
        mul_a = $signed({2'b0, raw_r}) - $signed({2'b0, slow_r});
        mul_b = $signed({2'b0, sa_r});
      end
      sffvc_pkg::DP_INTERP_MUL0: begin
        mul_a = 34'(p0_r);
        mul_b = $signed({3'b0, ds_c});
      end
      sffvc_pkg::DP_INTERP_MUL1: begin
        mul_a = $signed({17'b0, 17'(mag_r - 17'(s0_r))});
        mul_b = 18'(dp_c);
      end
      sffvc_pkg::DP_COMP_MUL: begin
        mul_a = 34'(duty_r[cmd.side]);
        mul_b = $signed({2'b0, gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // truncate toward zero on the arithmetic shifts
  assign rnd16_c = prod_r + (prod_r[51] ? 52'sd65535 : 52'sd0);
  assign rnd14_c = prod_r + (prod_r[51] ? 52'sd16383 : 52'sd0);
  assign upd_c   = $signed({2'b0, (cmd.op == sffvc_pkg::DP_FAST_UPD) ? fast_r : slow_r})
                   + 34'(rnd16_c >>> 16);
  assign comp_c  = rnd14_c >>> 14;

  assign vlo_c = {1'b0, vfl_r, 16'b0};
  assign vhi_c = {1'b0, vce_r, 16'b0};
  assign v1_c  = (slow_r < vlo_c) ? vlo_c : slow_r;
  assign v2_c  = (v1_c > vhi_c) ? vhi_c : v1_c;
  assign g1_c  = (div_q < 45'(gfl_r)) ? 45'(gfl_r) : div_q;

  assign q_c = nneg_r ? -$signed({1'b0, div_q[15:0]}) : $signed({1'b0, div_q[15:0]});

  assign div_start = (cmd.op == sffvc_pkg::DP_INTERP_DIV) || (cmd.op == sffvc_pkg::DP_GAIN_DIV);
  assign div_short = (cmd.op == sffvc_pkg::DP_INTERP_DIV);
  assign div_nd    = (cmd.op == sffvc_pkg::DP_INTERP_DIV)
                     ? 45'(num_r[31] ? -num_r : num_r)
                     : {ref_r, 30'b0};
  assign div_dv    = (cmd.op == sffvc_pkg::DP_INTERP_DIV) ? 32'(ds_c) : v2_c;

  sffvc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .short_mode (div_short),
    .dividend   (div_nd),
    .divisor    (div_dv),
    .quotient   (div_q),
    .done       (div_done)
  );

  // configuration and tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spike_r <= sffvc_pkg::RST_SPIKE_LIMIT;
      fa_r    <= sffvc_pkg::RST_FAST_ALPHA;
      sa_r    <= sffvc_pkg::RST_SLOW_ALPHA;
      ref_r   <= sffvc_pkg::RST_REFERENCE;
      vfl_r   <= sffvc_pkg::RST_VOLT_FLOOR;
      vce_r   <= sffvc_pkg::RST_VOLT_CEILING;
      gfl_r   <= sffvc_pkg::RST_GAIN_FLOOR;
      gce_r   <= sffvc_pkg::RST_GAIN_CEILING;
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < TABLE_POINTS; i++) begin
          spd_r[s][i] <= sffvc_pkg::dflt_speed(i);
          pwm_r[s][i] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sffvc_pkg::REG_SPIKE_LIMIT:  spike_r <= cfg_wdata[14:0];
          sffvc_pkg::REG_FAST_ALPHA:   fa_r    <= cfg_wdata;
          sffvc_pkg::REG_SLOW_ALPHA:   sa_r    <= cfg_wdata;
          sffvc_pkg::REG_REFERENCE:    ref_r   <= cfg_wdata[14:0];
          sffvc_pkg::REG_VOLT_FLOOR:   vfl_r   <= cfg_wdata[14:0];
          sffvc_pkg::REG_VOLT_CEILING: vce_r   <= cfg_wdata[14:0];
          sffvc_pkg::REG_GAIN_FLOOR:   gfl_r   <= cfg_wdata;
          sffvc_pkg::REG_GAIN_CEILING: gce_r   <= cfg_wdata;
          default: ;
        endcase
      end
      // drop point writes beyond the table
      if (cmd.load && (in_op == sffvc_pkg::OP_WRITE_POINT)
          && (32'(in_point_index) < 32'(TABLE_POINTS))) begin
        spd_r[in_table_side][IW'(in_point_index)] <= in_point_speed;
        pwm_r[in_table_side][IW'(in_point_index)] <= in_point_pwm;
      end
    end
  end

  // averages and search control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r        <= sffvc_pkg::RST_VOLTAGE_Q16;
      fast_r        <= sffvc_pkg::RST_VOLTAGE_Q16;
      srch_done_r   <= 1'b0;
      srch_interp_r <= 1'b0;
    end else begin
      case (cmd.op)
        sffvc_pkg::DP_FAST_UPD: fast_r <= upd_c[31:0];
        sffvc_pkg::DP_SLOW_UPD: slow_r <= upd_c[31:0];
        sffvc_pkg::DP_SRCH_INIT: begin
          srch_interp_r <= 1'b0;
          srch_done_r   <= (mag_c <= s_first_c) || (mag_c >= s_last_c);
        end
        sffvc_pkg::DP_SRCH_STEP: begin
          if (mag_r >= 17'(s0_r) && mag_r <= 17'(s_rd_c)) begin
            srch_done_r   <= 1'b1;
            srch_interp_r <= (s_rd_c != s0_r);
          end else if (idx_r == IW'(TABLE_POINTS - 1)) begin
            srch_done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vin_r <= in_voltage_mv;
      tl_r  <= in_left_target;
      tr_r  <= in_right_target;
    end
    case (cmd.op)
      sffvc_pkg::DP_LIMIT: begin
        if ({1'b0, raw_in_c} > hi_c) begin
          raw_r <= hi_c[31:0];
        end else if ($signed({2'b0, raw_in_c}) < lo_c) begin
          raw_r <= lo_c[31:0];
        end else begin
          raw_r <= raw_in_c;
        end
      end
      sffvc_pkg::DP_FAST_MUL, sffvc_pkg::DP_SLOW_MUL, sffvc_pkg::DP_INTERP_MUL0,
      sffvc_pkg::DP_COMP_MUL: begin
        prod_r <= mul_a * mul_b;
      end
      sffvc_pkg::DP_SRCH_INIT: begin
        mag_r  <= mag_c;
        tneg_r <= tgt_c[15];
        s0_r   <= spd_r[cmd.side][0];
        p0_r   <= pwm_r[cmd.side][0];
        idx_r  <= IW'(1);
        if (mag_c <= s_first_c) begin
          duty_r[cmd.side] <= sffvc_pkg::apply_sign(tgt_c[15], 17'(pwm_r[cmd.side][0]));
        end else if (mag_c >= s_last_c) begin
          duty_r[cmd.side] <= sffvc_pkg::apply_sign(tgt_c[15],
                                17'(pwm_r[cmd.side][TABLE_POINTS-1]));
        end
      end
      sffvc_pkg::DP_SRCH_STEP: begin
        if (mag_r >= 17'(s0_r) && mag_r <= 17'(s_rd_c)) begin
          s1_r <= s_rd_c;
          p1_r <= p_rd_c;
          // zero-width segment: lower point's duty
          if (s_rd_c == s0_r) begin
            duty_r[cmd.side] <= sffvc_pkg::apply_sign(tneg_r, 17'(p0_r));
          end
        end else if (idx_r == IW'(TABLE_POINTS - 1)) begin
          duty_r[cmd.side] <= '0;
        end else begin
          s0_r  <= s_rd_c;
          p0_r  <= p_rd_c;
          idx_r <= idx_r + IW'(1);
        end
      end
      sffvc_pkg::DP_INTERP_MUL1: begin
        num_r  <= prod_r[31:0];
        prod_r <= mul_a * mul_b;
      end
      sffvc_pkg::DP_INTERP_SUM: num_r <= num_r + prod_r[31:0];
      sffvc_pkg::DP_INTERP_DIV: nneg_r <= num_r[31];
      sffvc_pkg::DP_INTERP_DONE: duty_r[cmd.side] <= sffvc_pkg::apply_sign(tneg_r, q_c);
      sffvc_pkg::DP_GAIN_DIV: vz_r <= (v2_c == 32'd0);
      sffvc_pkg::DP_GAIN_DONE: begin
        if (vz_r || g1_c > 45'(gce_r)) begin
          gain_r <= gce_r;
        end else begin
          gain_r <= g1_c[15:0];
        end
      end
      sffvc_pkg::DP_COMP_DONE: begin
        if (comp_c > 52'sd10000) begin
          res_r[cmd.side] <= 15'sd10000;
        end else if (comp_c < -52'sd10000) begin
          res_r[cmd.side] <= -15'sd10000;
        end else begin
          res_r[cmd.side] <= comp_c[14:0];
        end
      end
      sffvc_pkg::DP_OUT_LOAD: begin
        outl_r <= res_r[0];
        outr_r <= res_r[1];
        outs_r <= slow_r[30:16];
        outf_r <= fast_r[30:16];
      end
      default: ;
    endcase
  end

  assign sts.srch_done   = srch_done_r;
  assign sts.srch_interp = srch_interp_r;
  assign sts.div_done    = div_done;

  assign out_left_ff_pwm  = outl_r;
  assign out_right_ff_pwm = outr_r;
  assign out_slow_avg_mv  = outs_r;
  assign out_fast_avg_mv  = outf_r;

endmodule
`default_nettype wire

// ===== rtl/core/sffvc_ctrl.sv =====
// Controller: sequences one control tick through the datapath and owns both handshakes.
// Depends on sffvc_pkg for the command and status structs.
`default_nettype none
module sffvc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_op,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output sffvc_pkg::cmd_t      cmd,
  input  wire sffvc_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_LIMIT, S_FMUL, S_FUPD, S_SMUL, S_SUPD,
    S_SINIT, S_SSTEP, S_IM0, S_IM1, S_ISUM, S_IDIV, S_IWAIT, S_IDONE,
    S_GDIV, S_GWAIT, S_GDONE, S_CMUL, S_CDONE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;
  logic   out_free;

  assign load     = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load      = load;
    cmd.side      = side_r;
    cmd.op        = sffvc_pkg::DP_NOP;
    case (state_r)
      S_IDLE:  if (load && in_op == sffvc_pkg::OP_TICK) state_nxt = S_LIMIT;
      S_LIMIT: begin cmd.op = sffvc_pkg::DP_LIMIT;    state_nxt = S_FMUL; end
      S_FMUL:  begin cmd.op = sffvc_pkg::DP_FAST_MUL; state_nxt = S_FUPD; end
      S_FUPD:  begin cmd.op = sffvc_pkg::DP_FAST_UPD; state_nxt = S_SMUL; end
      S_SMUL:  begin cmd.op = sffvc_pkg::DP_SLOW_MUL; state_nxt = S_SUPD; end
      S_SUPD:  begin
        cmd.op    = sffvc_pkg::DP_SLOW_UPD;
        side_nxt  = 1'b0;
        state_nxt = S_SINIT;
      end
      S_SINIT: begin cmd.op = sffvc_pkg::DP_SRCH_INIT; state_nxt = S_SSTEP; end
      S_SSTEP: begin
        // advance the search until a segment or an end point settles
        if (!sts.srch_done) begin
          cmd.op = sffvc_pkg::DP_SRCH_STEP;
        end else if (sts.srch_interp) begin
          state_nxt = S_IM0;
        end else if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_SINIT;
        end else begin
          state_nxt = S_GDIV;
        end
      end
      S_IM0:   begin cmd.op = sffvc_pkg::DP_INTERP_MUL0; state_nxt = S_IM1; end
      S_IM1:   begin cmd.op = sffvc_pkg::DP_INTERP_MUL1; state_nxt = S_ISUM; end
      S_ISUM:  begin cmd.op = sffvc_pkg::DP_INTERP_SUM;  state_nxt = S_IDIV; end
      S_IDIV:  begin cmd.op = sffvc_pkg::DP_INTERP_DIV;  state_nxt = S_IWAIT; end
      S_IWAIT: if (sts.div_done) state_nxt = S_IDONE;
      S_IDONE: begin
        cmd.op = sffvc_pkg::DP_INTERP_DONE;
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_SINIT;
        end else begin
          state_nxt = S_GDIV;
        end
      end
      S_GDIV:  begin cmd.op = sffvc_pkg::DP_GAIN_DIV; state_nxt = S_GWAIT; end
      S_GWAIT: if (sts.div_done) state_nxt = S_GDONE;
      S_GDONE: begin
        cmd.op    = sffvc_pkg::DP_GAIN_DONE;
        side_nxt  = 1'b0;
        state_nxt = S_CMUL;
      end
      S_CMUL:  begin cmd.op = sffvc_pkg::DP_COMP_MUL; state_nxt = S_CDONE; end
      S_CDONE: begin
        cmd.op = sffvc_pkg::DP_COMP_DONE;
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_CMUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.op        = sffvc_pkg::DP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/speed_feedforward_voltage_comp_unit.sv =====
// Top level of the speed feedforward voltage compensation block.
// Joins sffvc_ctrl and sffvc_dp; types and defaults from sffvc_pkg.
//
// Usage:
//  Input channel (in_valid / in_stall): in_op selects a point write or a control tick.
//  A point write updates one entry of the left or right speed-to-duty table in the
//  transfer cycle and produces no result; the next item can follow at once.
//  A control tick limits the voltage sample, updates the fast and slow averages,
//  interpolates both wheel duties and scales them by reference over slow voltage.
//  Its result leaves on the output channel (out_valid / out_stall).
//  A tick scans each wheel's table segments serially; a wheel that interpolates, and
//  then the gain, each use the shared one bit per cycle divider (32 quotient bits per
//  interpolation, 45 for the gain); one tick is in flight at a time.
//  The finished result sits in an output register, so a stalled receiver holds only
//  that register; a new item is taken meanwhile and waits for it only at its end.
//  The user writes configuration (cfg_we / cfg_index / cfg_wdata) only while idle;
//  the block does not enforce this. Reset restores register defaults, default table
//  speeds with zero duty and both averages at 12000 mV.
`default_nettype none
module speed_feedforward_voltage_comp_unit #(
  parameter int TABLE_POINTS = sffvc_pkg::TABLE_POINTS_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic [14:0]        in_voltage_mv,
  input  wire logic signed [15:0] in_left_target,
  input  wire logic signed [15:0] in_right_target,
  input  wire logic               in_table_side,
  input  wire logic [3:0]         in_point_index,
  input  wire logic [14:0]        in_point_speed,
  input  wire logic signed [14:0] in_point_pwm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [14:0]      out_left_ff_pwm,
  output logic signed [14:0]      out_right_ff_pwm,
  output logic [14:0]             out_slow_avg_mv,
  output logic [14:0]             out_fast_avg_mv,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  sffvc_pkg::cmd_t cmd;
  sffvc_pkg::sts_t sts;

  sffvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sffvc_dp #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_voltage_mv    (in_voltage_mv),
    .in_left_target   (in_left_target),
    .in_right_target  (in_right_target),
    .in_table_side    (in_table_side),
    .in_point_index   (in_point_index),
    .in_point_speed   (in_point_speed),
    .in_point_pwm     (in_point_pwm),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_left_ff_pwm  (out_left_ff_pwm),
    .out_right_ff_pwm (out_right_ff_pwm),
    .out_slow_avg_mv  (out_slow_avg_mv),
    .out_fast_avg_mv  (out_fast_avg_mv)
  );

endmodule
`default_nettype wire

// ===== rtl/core/sffvc_chk.sv =====
// Port-level checker for the speed feedforward voltage compensation block, with its bind.
// Depends on the top level's ports only.
`default_nettype none
module sffvc_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               in_op,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [14:0] out_left_ff_pwm,
  input wire logic signed [14:0] out_right_ff_pwm
);

  // reset leaves the block ready for a transfer
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // a table write completes in its transfer cycle
  a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_op |=> !in_stall)
    else $error("table write stalled the input");

  // a tick occupies the sequencer
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op |=> in_stall)
    else $error("tick did not start the sequence");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_ff_pwm <= 15'sd10000) && (out_left_ff_pwm >= -15'sd10000)
                  && (out_right_ff_pwm <= 15'sd10000) && (out_right_ff_pwm >= -15'sd10000))
    else $error("duty outside saturation range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind speed_feedforward_voltage_comp_unit sffvc_chk u_sffvc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_left_ff_pwm  (out_left_ff_pwm),
  .out_right_ff_pwm (out_right_ff_pwm)
);
`default_nettype wire

// ===== tb/speed_feedforward_voltage_comp_unit_test.sv =====
// Self-checking testbench for speed_feedforward_voltage_comp_unit: table writes and ticks,
// a bit-exact duty/voltage predictor and a clocked driver and monitor with random idling.
// Depends on sffvc_pkg and the top level only.
module speed_feedforward_voltage_comp_unit_test;

  localparam int NPTS = sffvc_pkg::TABLE_POINTS_DFLT;
  localparam int SETTLE = 300;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic               op;
    logic [14:0]        voltage;
    logic signed [15:0] left_t;
    logic signed [15:0] right_t;
    logic               side;
    logic [3:0]         idx;
    logic [14:0]        speed;
    logic signed [14:0] pwm;
  } cmd_item_t;

  typedef struct {
    logic signed [14:0] left_pwm;
    logic signed [14:0] right_pwm;
    logic [14:0]        slow_mv;
    logic [14:0]        fast_mv;
  } duty_res_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_op, in_table_side;
  logic [14:0] in_voltage_mv, in_point_speed;
  logic signed [15:0] in_left_target, in_right_target;
  logic [3:0] in_point_index;
  logic signed [14:0] in_point_pwm;
  logic out_valid, out_stall;
  logic signed [14:0] out_left_ff_pwm, out_right_ff_pwm;
  logic [14:0] out_slow_avg_mv, out_fast_avg_mv;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;

  speed_feedforward_voltage_comp_unit dut (.*);

  // predictor state
  longint tbl_speed [2][NPTS];
  longint tbl_duty  [2][NPTS];
  longint slow_q, fast_q;
  longint reg_val [8];

  cmd_item_t pending_cmds[$];
  duty_res_t expected_duties[$];
  int mismatches = 0;
  int cycles = 0;
  bit feed_en = 0, calm = 0, hold_req = 0, hold_done = 0;
  int gap_left = 0, stall_left = 0, hold_cycles = 0;

  function automatic longint interp_duty(longint target, int s);
    longint mag, sg, ds, num;
    mag = target < 0 ? -target : target;
    sg = target < 0 ? -1 : 1;
    if (mag <= tbl_speed[s][0]) return sg * tbl_duty[s][0];
    if (mag >= tbl_speed[s][NPTS-1]) return sg * tbl_duty[s][NPTS-1];
    for (int i = 0; i < NPTS - 1; i++) begin
      if (mag >= tbl_speed[s][i] && mag <= tbl_speed[s][i+1]) begin
        ds = tbl_speed[s][i+1] - tbl_speed[s][i];
        if (ds == 0) return sg * tbl_duty[s][i];
        num = tbl_duty[s][i] * ds + (mag - tbl_speed[s][i]) * (tbl_duty[s][i+1] - tbl_duty[s][i]);
        return sg * (num / ds);
      end
    end
    return 0;
  endfunction

  function automatic longint scale_duty(longint duty, longint gain);
    longint r;
    r = (duty * gain) / 16384;
    if (r > 10000) r = 10000;
    if (r < -10000) r = -10000;
    return r;
  endfunction

  function automatic void predict_duty(cmd_item_t c);
    longint raw, lim, v, gain, dl, dr;
    duty_res_t e;
    if (c.op == sffvc_pkg::OP_WRITE_POINT) begin
      if (c.idx < NPTS) begin
        tbl_speed[c.side][c.idx] = c.speed;
        tbl_duty[c.side][c.idx] = c.pwm;
      end
      return;
    end
    raw = longint'(c.voltage) * 65536;
    lim = reg_val[sffvc_pkg::REG_SPIKE_LIMIT] * 65536;
    if (raw > slow_q + lim) raw = slow_q + lim;
    else if (raw < slow_q - lim) raw = slow_q - lim;
    fast_q = fast_q + (reg_val[sffvc_pkg::REG_FAST_ALPHA] * (raw - fast_q)) / 65536;
    slow_q = slow_q + (reg_val[sffvc_pkg::REG_SLOW_ALPHA] * (raw - slow_q)) / 65536;
    dl = interp_duty(c.left_t, 0);
    dr = interp_duty(c.right_t, 1);
    v = slow_q;
    if (v < reg_val[sffvc_pkg::REG_VOLT_FLOOR] * 65536)
      v = reg_val[sffvc_pkg::REG_VOLT_FLOOR] * 65536;
    if (v > reg_val[sffvc_pkg::REG_VOLT_CEILING] * 65536)
      v = reg_val[sffvc_pkg::REG_VOLT_CEILING] * 65536;
    if (v <= 0) gain = reg_val[sffvc_pkg::REG_GAIN_CEILING];
    else begin
      gain = (reg_val[sffvc_pkg::REG_REFERENCE] << 30) / v;
      if (gain < reg_val[sffvc_pkg::REG_GAIN_FLOOR]) gain = reg_val[sffvc_pkg::REG_GAIN_FLOOR];
      if (gain > reg_val[sffvc_pkg::REG_GAIN_CEILING])
        gain = reg_val[sffvc_pkg::REG_GAIN_CEILING];
    end
    e.left_pwm = 15'(scale_duty(dl, gain));
    e.right_pwm = 15'(scale_duty(dr, gain));
    e.slow_mv = 15'(slow_q / 65536);
    e.fast_mv = 15'(fast_q / 65536);
    expected_duties.push_back(e);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("speed_feedforward_voltage_comp_unit regression: fail");
      $finish;
    end
  end

  // driver: hold the payload until the transfer, then pick the next item or a gap
  always @(posedge clk) begin
    logic nv;
    cmd_item_t c;
    nv = in_valid;
    if (!rst_n) nv = 0;
    else begin
      if (in_valid && !in_stall) begin
        predict_duty('{in_op, in_voltage_mv, in_left_target, in_right_target,
                       in_table_side, in_point_index, in_point_speed, in_point_pwm});
        nv = 0;
        if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 16);
      end
      if (!nv) begin
        if (gap_left > 0) gap_left--;
        else if (feed_en && pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_op <= c.op;
          in_voltage_mv <= c.voltage;
          in_left_target <= c.left_t;
          in_right_target <= c.right_t;
          in_table_side <= c.side;
          in_point_index <= c.idx;
          in_point_speed <= c.speed;
          in_point_pwm <= c.pwm;
          nv = 1;
        end
      end
    end
    in_valid <= nv;
  end

  // receiver stall: one long hold-off on request, otherwise random bursts unless calm
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else if (hold_req && !hold_done) begin
      out_stall <= 1;
      hold_cycles++;
      if (hold_cycles >= 600) hold_done = 1;
    end else if (calm) out_stall <= 0;
    else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      if ($urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 16);
    end
  end

  // monitor
  always @(posedge clk) begin
    duty_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
      end else begin
        e = expected_duties.pop_front();
        if (e.left_pwm !== out_left_ff_pwm || e.right_pwm !== out_right_ff_pwm ||
            e.slow_mv !== out_slow_avg_mv || e.fast_mv !== out_fast_avg_mv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp L%0d R%0d s%0d f%0d got L%0d R%0d s%0d f%0d",
                     e.left_pwm, e.right_pwm, e.slow_mv, e.fast_mv, out_left_ff_pwm,
                     out_right_ff_pwm, out_slow_avg_mv, out_fast_avg_mv);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= 16'(val);
    reg_val[idx] = (idx == sffvc_pkg::REG_FAST_ALPHA || idx == sffvc_pkg::REG_SLOW_ALPHA ||
                    idx == sffvc_pkg::REG_GAIN_FLOOR || idx == sffvc_pkg::REG_GAIN_CEILING) ?
                   (val & 16'hFFFF) : (val & 15'h7FFF);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic push_point(bit side, int idx, int speed, int pwm);
    cmd_item_t c;
    c = '{sffvc_pkg::OP_WRITE_POINT, 15'($urandom), 16'($urandom), 16'($urandom), side,
          4'(idx), 15'(speed), 15'(pwm)};
    pending_cmds.push_back(c);
  endtask

  task automatic push_tick(int volt, int lt, int rt);
    cmd_item_t c;
    c = '{sffvc_pkg::OP_TICK, 15'(volt), 16'(lt), 16'(rt), 1'($urandom), 4'($urandom),
          15'($urandom), 15'($urandom)};
    pending_cmds.push_back(c);
  endtask

  // ascending table with random steps, occasionally a repeated speed
  task automatic push_sorted_table(bit side, int top);
    int s;
    s = $urandom_range(0, 20);
    for (int i = 0; i < NPTS; i++) begin
      push_point(side, i, s, $urandom_range(0, 20000) - 10000);
      if ($urandom_range(0, 7) != 0) s += $urandom_range(1, top);
    end
  endtask

  function automatic int rand_target();
    int m;
    case ($urandom_range(0, 9))
      0: m = $urandom_range(0, 65535) - 32768;
      1: m = 0;
      default: m = $urandom_range(0, 400);
    endcase
    if ($urandom_range(0, 1)) m = -m;
    return m;
  endfunction

  task automatic push_random(int n);
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 19))
        0: begin push_sorted_table($urandom_range(0, 1), $urandom_range(2, 60)); k += NPTS; end
        1: begin
          push_point($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 32767),
                     $urandom_range(0, 32767));
          k++;
        end
        default: begin
          push_tick($urandom_range(0, 3) == 0 ? $urandom_range(0, 20000) :
                    $urandom_range(5000, 17000), rand_target(), rand_target());
          k++;
        end
      endcase
    end
  endtask

  task automatic drain();
    feed_en = 1;
    wait (pending_cmds.size() == 0 && !in_valid && expected_duties.size() == 0);
    repeat (SETTLE) @(posedge clk);
    feed_en = 0;
  endtask

  initial begin
    in_valid = 0; in_op = 0; in_voltage_mv = 0; in_left_target = 0; in_right_target = 0;
    in_table_side = 0; in_point_index = 0; in_point_speed = 0; in_point_pwm = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0; rst_n = 0;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < NPTS; i++) begin
        tbl_speed[s][i] = sffvc_pkg::dflt_speed(i);
        tbl_duty[s][i] = 0;
      end
    slow_q = 64'd12000 * 65536;
    fast_q = slow_q;
    reg_val = '{500, 16384, 655, 12000, 6000, 16800, 13107, 26214};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: default table, extremes, zero-width and unsorted segments, ignored writes
    push_tick(12000, 0, -32768);
    push_point(0, 0, 0, -10000);
    push_point(0, 8, 32767, 10000);
    push_point(1, 0, 5, 10000);
    push_point(1, 3, 20, 777);
    push_point(1, 8, 200, -10000);
    push_point(0, 9, 1, 1);
    push_point(1, 15, 32767, -1);
    push_tick(20000, 32767, -32768);
    push_tick(0, -15, 3);
    push_tick(0, 100, -25);
    push_tick(16384, -32767, 199);
    push_point(0, 4, 30, 5000);
    push_tick(12000, 30, 20);
    push_point(0, 5, 10, -3000);
    push_tick(12000, 45, -60);
    push_tick(12000, -1, 32767);
    drain();

    // stall pressure with default settings
    hold_req = 1;
    push_random(60);
    drain();

    write_reg(sffvc_pkg::REG_SPIKE_LIMIT, 0);
    write_reg(sffvc_pkg::REG_FAST_ALPHA, 65535);
    write_reg(sffvc_pkg::REG_SLOW_ALPHA, 0);
    write_reg(sffvc_pkg::REG_GAIN_FLOOR, 0);
    write_reg(sffvc_pkg::REG_GAIN_CEILING, 65535);
    push_random(250);
    drain();

    write_reg(sffvc_pkg::REG_SPIKE_LIMIT, 20000);
    write_reg(sffvc_pkg::REG_FAST_ALPHA, 0);
    write_reg(sffvc_pkg::REG_SLOW_ALPHA, 65535);
    write_reg(sffvc_pkg::REG_REFERENCE, 1);
    write_reg(sffvc_pkg::REG_VOLT_FLOOR, 1);
    write_reg(sffvc_pkg::REG_VOLT_CEILING, 20000);
    push_random(250);
    drain();

    // floors above ceilings
    write_reg(sffvc_pkg::REG_REFERENCE, 20000);
    write_reg(sffvc_pkg::REG_VOLT_FLOOR, 20000);
    write_reg(sffvc_pkg::REG_VOLT_CEILING, 1);
    write_reg(sffvc_pkg::REG_GAIN_FLOOR, 65535);
    write_reg(sffvc_pkg::REG_GAIN_CEILING, 0);
    push_random(250);
    drain();

    write_reg(sffvc_pkg::REG_SPIKE_LIMIT, $urandom_range(0, 32767));
    write_reg(sffvc_pkg::REG_FAST_ALPHA, $urandom_range(0, 65535));
    write_reg(sffvc_pkg::REG_SLOW_ALPHA, $urandom_range(0, 65535));
    write_reg(sffvc_pkg::REG_REFERENCE, $urandom_range(1, 32767));
    write_reg(sffvc_pkg::REG_VOLT_FLOOR, $urandom_range(1, 8000));
    write_reg(sffvc_pkg::REG_VOLT_CEILING, $urandom_range(12000, 32767));
    write_reg(sffvc_pkg::REG_GAIN_FLOOR, $urandom_range(0, 16384));
    write_reg(sffvc_pkg::REG_GAIN_CEILING, $urandom_range(16384, 65535));
    push_random(300);
    drain();

    write_reg(sffvc_pkg::REG_SPIKE_LIMIT, 500);
    write_reg(sffvc_pkg::REG_FAST_ALPHA, 16384);
    write_reg(sffvc_pkg::REG_SLOW_ALPHA, 655);
    write_reg(sffvc_pkg::REG_REFERENCE, 12000);
    write_reg(sffvc_pkg::REG_VOLT_FLOOR, 6000);
    write_reg(sffvc_pkg::REG_VOLT_CEILING, 16800);
    write_reg(sffvc_pkg::REG_GAIN_FLOOR, 13107);
    write_reg(sffvc_pkg::REG_GAIN_CEILING, 26214);
    push_random(300);
    drain();

    // closing stretch without idling on either side
    calm = 1;
    push_random(150);
    drain();

    if (mismatches == 0 && expected_duties.size() == 0)
      $display("speed_feedforward_voltage_comp_unit regression: pass");
    else
      $display("speed_feedforward_voltage_comp_unit regression: fail");
    $finish;
  end
endmodule
